// ----- design/unix_time_calendar_convert_macros.svh -----
// assertion macros for the port-level checker
`ifndef UNIX_TIME_CALENDAR_CONVERT_MACROS_SVH
`define UNIX_TIME_CALENDAR_CONVERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define UTCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define UTCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/utcc_pkg.sv -----
// package: types, constants, microcode table and calendar helpers
package utcc_pkg;

    localparam int unsigned MAX_YEAR_DEF = 9999;

    localparam int unsigned SECS_W = 38;
    localparam int unsigned YEAR_W = 14;
    localparam int unsigned DAYS_W = 22;
    localparam int unsigned PC_W   = 4;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 14'd1970;
    localparam logic [6:0]        C100_INIT  = 7'd70;
    localparam logic [8:0]        C400_INIT  = 9'd370;
    localparam logic [16:0]       SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0]       SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]        SECS_PER_MIN  = 6'd60;
    localparam logic [8:0]        DAYS_LEAP   = 9'd366;
    localparam logic [8:0]        DAYS_COMMON = 9'd365;
    localparam logic [24:0]       YEAR_SECS_LEAP   = 25'd31622400;
    localparam logic [24:0]       YEAR_SECS_COMMON = 25'd31536000;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t OP0_ENTRY = 4'd0;
    localparam pc_t OP1_ENTRY = 4'd8;

    typedef struct packed {
        logic        op;
        logic [37:0] epoch_seconds;
        logic [13:0] cal_year;
        logic [3:0]  cal_month;
        logic [4:0]  cal_day;
        logic [4:0]  cal_hour;
        logic [5:0]  cal_minute;
        logic [5:0]  cal_second;
    } utcc_cmd_t;

    typedef struct packed {
        logic [37:0] result_seconds;
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
    } utcc_rsp_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } utcc_state_t;

    typedef enum logic [3:0] {
        A_YADD,
        A_MADD,
        A_DADD,
        A_MULDAY,
        A_ADDH,
        A_ADDMS,
        A_SAT,
        A_LOADS,
        A_YSUB,
        A_MSUB,
        A_DSUB,
        A_HSUB,
        A_NSUB,
        A_DONE
    } utcc_act_t;

    typedef enum logic [2:0] {
        C_ALW,
        C_YLT,
        C_MLT,
        C_YGE,
        C_MGE,
        C_DGE,
        C_HGE,
        C_NGE
    } utcc_cond_t;

    typedef struct packed {
        utcc_act_t  act;
        utcc_cond_t cond;
        pc_t        tgt;
    } utcc_uword_t;

    typedef struct packed {
        logic      load;
        logic      exec;
        utcc_act_t act;
    } utcc_ctl_t;

    typedef struct packed {
        logic ylt;
        logic mlt;
        logic yge;
        logic mge;
        logic dge;
        logic hge;
        logic nge;
    } utcc_flags_t;

    // when the condition holds the action runs and control moves to tgt,
    // otherwise control falls through to the next step
    function automatic utcc_uword_t ucode(input pc_t pc);
        utcc_uword_t w;
        unique case (pc)
            4'd0:    w = '{A_YADD,   C_YLT, 4'd0};
            4'd1:    w = '{A_MADD,   C_MLT, 4'd1};
            4'd2:    w = '{A_DADD,   C_ALW, 4'd3};
            4'd3:    w = '{A_MULDAY, C_ALW, 4'd4};
            4'd4:    w = '{A_ADDH,   C_ALW, 4'd5};
            4'd5:    w = '{A_ADDMS,  C_ALW, 4'd6};
            4'd6:    w = '{A_SAT,    C_ALW, 4'd7};
            4'd7:    w = '{A_DONE,   C_ALW, 4'd7};
            4'd8:    w = '{A_LOADS,  C_ALW, 4'd9};
            4'd9:    w = '{A_YSUB,   C_YGE, 4'd9};
            4'd10:   w = '{A_MSUB,   C_MGE, 4'd10};
            4'd11:   w = '{A_DSUB,   C_DGE, 4'd11};
            4'd12:   w = '{A_HSUB,   C_HGE, 4'd12};
            4'd13:   w = '{A_NSUB,   C_NGE, 4'd13};
            default: w = '{A_DONE,   C_ALW, 4'd14};
        endcase
        return w;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // seconds in month m
    function automatic logic [21:0] month_secs(input logic [3:0] m, input logic leap);
        logic [21:0] s;
        unique case (month_days(m, leap))
            5'd28:   s = 22'd2419200;
            5'd29:   s = 22'd2505600;
            5'd30:   s = 22'd2592000;
            default: s = 22'd2678400;
        endcase
        return s;
    endfunction

    // last second of year max_year, evaluated at elaboration
    function automatic logic [SECS_W-1:0] last_second(input int unsigned max_year);
        longint unsigned n1;
        longint unsigned n0;
        longint unsigned days;
        n1   = longint'(max_year);
        n0   = 64'd1969;
        days = 64'd365 * (n1 + 64'd1 - 64'd1970)
             + (n1 / 4 - n1 / 100 + n1 / 400)
             - (n0 / 4 - n0 / 100 + n0 / 400);
        return SECS_W'(days * 64'd86400 - 64'd1);
    endfunction

endpackage

// ----- design/unix_time_calendar_convert.sv -----
// top level: microcode sequencer and command handshake
//
// Converts between Unix epoch seconds and Gregorian calendar fields (1970
// epoch, no leap seconds). A command is taken when start is high while busy
// is low; busy then stays high until the result is posted. The result is
// shown on rsp for exactly one cycle with done high, and must be captured
// then: there is no way to hold it. How long busy stays high is set by the
// year walk, which advances one year per cycle; op 1 then counts off months,
// days, hours and minutes one per cycle by subtracting whole seconds, while
// op 0 adds the month walk and sums. A new command may be issued in the
// cycle that done is high.
module unix_time_calendar_convert #(
    parameter int unsigned MAX_YEAR = utcc_pkg::MAX_YEAR_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  utcc_pkg::utcc_cmd_t cmd,
    output logic                busy,
    output logic                done,
    output utcc_pkg::utcc_rsp_t rsp
);

    utcc_pkg::utcc_state_t state_reg, state_next;
    utcc_pkg::pc_t         pc_reg, pc_next;
    logic                  done_reg, done_next;
    utcc_pkg::utcc_uword_t uword;
    utcc_pkg::utcc_ctl_t   ctl;
    utcc_pkg::utcc_flags_t flags;
    logic                  cond_ok;

    assign uword = utcc_pkg::ucode(pc_reg);
    assign busy  = state_reg == utcc_pkg::ST_RUN;
    assign done  = done_reg;

    always_comb
    begin
        unique case (uword.cond)
            utcc_pkg::C_ALW: cond_ok = 1'b1;
            utcc_pkg::C_YLT: cond_ok = flags.ylt;
            utcc_pkg::C_MLT: cond_ok = flags.mlt;
            utcc_pkg::C_YGE: cond_ok = flags.yge;
            utcc_pkg::C_MGE: cond_ok = flags.mge;
            utcc_pkg::C_DGE: cond_ok = flags.dge;
            utcc_pkg::C_HGE: cond_ok = flags.hge;
            utcc_pkg::C_NGE: cond_ok = flags.nge;
            default:         cond_ok = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        done_next  = 1'b0;
        ctl.load   = 1'b0;
        ctl.exec   = 1'b0;
        ctl.act    = uword.act;
        unique case (state_reg)
            utcc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    pc_next    = cmd.op ? utcc_pkg::OP1_ENTRY : utcc_pkg::OP0_ENTRY;
                    state_next = utcc_pkg::ST_RUN;
                end
            end
            utcc_pkg::ST_RUN:
            begin
                if (cond_ok)
                begin
                    ctl.exec = 1'b1;
                    pc_next  = uword.tgt;
                    if (uword.act == utcc_pkg::A_DONE)
                    begin
                        state_next = utcc_pkg::ST_IDLE;
                        done_next  = 1'b1;
                    end
                end
                else
                    pc_next = pc_reg + utcc_pkg::PC_W'(1);
            end
            default:
                state_next = utcc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= utcc_pkg::ST_IDLE;
            pc_reg    <= utcc_pkg::OP0_ENTRY;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            done_reg  <= done_next;
        end
    end

    utcc_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .clk   (clk),
        .ctl   (ctl),
        .cmd   (cmd),
        .flags (flags),
        .rsp   (rsp)
    );

endmodule

// ----- design/utcc_datapath.sv -----
// datapath: working registers, calendar walk and seconds count-down
module utcc_datapath #(
    parameter int unsigned MAX_YEAR = utcc_pkg::MAX_YEAR_DEF
) (
    input  logic                clk,
    input  utcc_pkg::utcc_ctl_t ctl,
    input  utcc_pkg::utcc_cmd_t cmd,
    output utcc_pkg::utcc_flags_t flags,
    output utcc_pkg::utcc_rsp_t rsp
);

    localparam logic [utcc_pkg::SECS_W-1:0] LIMIT    = utcc_pkg::last_second(MAX_YEAR);
    localparam logic [utcc_pkg::YEAR_W-1:0] MAX_Y    = utcc_pkg::YEAR_W'(MAX_YEAR);

    utcc_pkg::utcc_cmd_t cmd_reg, cmd_next;
    utcc_pkg::utcc_rsp_t rsp_reg, rsp_next;
    logic [37:0] acc_reg, acc_next;
    logic [37:0] res_reg, res_next;
    logic [utcc_pkg::DAYS_W-1:0] days_reg, days_next;
    logic [13:0] yr_reg, yr_next;
    logic [6:0]  c100_reg, c100_next;
    logic [8:0]  c400_reg, c400_next;
    logic [3:0]  mon_reg, mon_next;
    logic [13:0] ytgt_reg, ytgt_next;
    logic [3:0]  mtgt_reg, mtgt_next;
    logic [4:0]  dtgt_reg, dtgt_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;

    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [24:0] ysecs;
    logic [21:0] msecs;
    logic [37:0] secs_clamp;

    assign leap = ((yr_reg[1:0] == 2'd0) && (c100_reg != 7'd0)) || (c400_reg == 9'd0);
    assign ylen = leap ? utcc_pkg::DAYS_LEAP : utcc_pkg::DAYS_COMMON;
    assign mlen = utcc_pkg::month_days(mon_reg, leap);
    assign ysecs = leap ? utcc_pkg::YEAR_SECS_LEAP : utcc_pkg::YEAR_SECS_COMMON;
    assign msecs = utcc_pkg::month_secs(mon_reg, leap);
    assign secs_clamp = (cmd_reg.epoch_seconds > LIMIT) ? LIMIT : cmd_reg.epoch_seconds;

    assign flags.ylt = yr_reg < ytgt_reg;
    assign flags.mlt = mon_reg < mtgt_reg;
    assign flags.yge = acc_reg >= 38'(ysecs);
    assign flags.mge = (mon_reg < 4'd12) && (acc_reg >= 38'(msecs));
    assign flags.dge = acc_reg >= 38'(utcc_pkg::SECS_PER_DAY);
    assign flags.hge = acc_reg >= 38'(utcc_pkg::SECS_PER_HOUR);
    assign flags.nge = acc_reg >= 38'(utcc_pkg::SECS_PER_MIN);

    assign rsp = rsp_reg;

    always_comb
    begin
        cmd_next  = cmd_reg;
        rsp_next  = rsp_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        days_next = days_reg;
        yr_next   = yr_reg;
        c100_next = c100_reg;
        c400_next = c400_reg;
        mon_next  = mon_reg;
        ytgt_next = ytgt_reg;
        mtgt_next = mtgt_reg;
        dtgt_next = dtgt_reg;
        hour_next = hour_reg;
        min_next  = min_reg;

        if (ctl.load)
        begin
            cmd_next  = cmd;
            yr_next   = utcc_pkg::EPOCH_YEAR;
            c100_next = utcc_pkg::C100_INIT;
            c400_next = utcc_pkg::C400_INIT;
            mon_next  = 4'd1;
            days_next = '0;
            hour_next = '0;
            min_next  = '0;
            if (cmd.cal_year < utcc_pkg::EPOCH_YEAR)
                ytgt_next = utcc_pkg::EPOCH_YEAR;
            else if (cmd.cal_year > MAX_Y)
                ytgt_next = MAX_Y;
            else
                ytgt_next = cmd.cal_year;
            if (cmd.cal_month == 4'd0)
                mtgt_next = 4'd1;
            else if (cmd.cal_month > 4'd12)
                mtgt_next = 4'd12;
            else
                mtgt_next = cmd.cal_month;
            dtgt_next = (cmd.cal_day == 5'd0) ? 5'd1 : cmd.cal_day;
        end
        else if (ctl.exec)
        begin
            unique case (ctl.act)
                utcc_pkg::A_YADD, utcc_pkg::A_YSUB:
                begin
                    if (ctl.act == utcc_pkg::A_YADD)
                        days_next = days_reg + 22'(ylen);
                    else
                        acc_next = acc_reg - 38'(ysecs);
                    yr_next   = yr_reg + 14'd1;
                    c100_next = (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                    c400_next = (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                end
                utcc_pkg::A_MADD:
                begin
                    days_next = days_reg + 22'(mlen);
                    mon_next  = mon_reg + 4'd1;
                end
                utcc_pkg::A_MSUB:
                begin
                    acc_next = acc_reg - 38'(msecs);
                    mon_next = mon_reg + 4'd1;
                end
                utcc_pkg::A_DADD:
                    days_next = days_reg + 22'(dtgt_reg - 5'd1);
                utcc_pkg::A_MULDAY:
                    acc_next = 38'(days_reg) * 38'(utcc_pkg::SECS_PER_DAY);
                utcc_pkg::A_ADDH:
                    acc_next = acc_reg
                             + 38'(17'(cmd_reg.cal_hour) * 17'(utcc_pkg::SECS_PER_HOUR));
                utcc_pkg::A_ADDMS:
                    acc_next = acc_reg
                             + 38'(12'(cmd_reg.cal_minute) * 12'(utcc_pkg::SECS_PER_MIN))
                             + 38'(cmd_reg.cal_second);
                utcc_pkg::A_SAT:
                    res_next = (acc_reg > LIMIT) ? LIMIT : acc_reg;
                utcc_pkg::A_LOADS:
                begin
                    acc_next = secs_clamp;
                    res_next = secs_clamp;
                end
                utcc_pkg::A_DSUB:
                begin
                    acc_next  = acc_reg - 38'(utcc_pkg::SECS_PER_DAY);
                    days_next = days_reg + 22'd1;
                end
                utcc_pkg::A_HSUB:
                begin
                    acc_next  = acc_reg - 38'(utcc_pkg::SECS_PER_HOUR);
                    hour_next = hour_reg + 5'd1;
                end
                utcc_pkg::A_NSUB:
                begin
                    acc_next = acc_reg - 38'(utcc_pkg::SECS_PER_MIN);
                    min_next = min_reg + 6'd1;
                end
                utcc_pkg::A_DONE:
                begin
                    rsp_next.result_seconds = res_reg;
                    if (cmd_reg.op)
                    begin
                        rsp_next.out_year   = yr_reg;
                        rsp_next.out_month  = mon_reg;
                        rsp_next.out_day    = days_reg[4:0] + 5'd1;
                        rsp_next.out_hour   = hour_reg;
                        rsp_next.out_minute = min_reg;
                        rsp_next.out_second = acc_reg[5:0];
                    end
                    else
                    begin
                        rsp_next.out_year   = cmd_reg.cal_year;
                        rsp_next.out_month  = cmd_reg.cal_month;
                        rsp_next.out_day    = cmd_reg.cal_day;
                        rsp_next.out_hour   = cmd_reg.cal_hour;
                        rsp_next.out_minute = cmd_reg.cal_minute;
                        rsp_next.out_second = cmd_reg.cal_second;
                    end
                end
                default:
                    acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        rsp_reg  <= rsp_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        days_reg <= days_next;
        yr_reg   <= yr_next;
        c100_reg <= c100_next;
        c400_reg <= c400_next;
        mon_reg  <= mon_next;
        ytgt_reg <= ytgt_next;
        mtgt_reg <= mtgt_next;
        dtgt_reg <= dtgt_next;
        hour_reg <= hour_next;
        min_reg  <= min_next;
    end

endmodule

// ----- design/utcc_checker.sv -----
// port-level checker for the converter, bound to the top level
`include "unix_time_calendar_convert_macros.svh"

module utcc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    `UTCC_ASSERT_NEXT(a_start_busy, start && !busy, busy, "transfer accepted but busy not raised")
    `UTCC_ASSERT_NOW(a_done_idle, done, !busy, "result posted while still busy")
    `UTCC_ASSERT_NOW(a_fell_done, $fell(busy), done, "busy dropped without a result")
    `UTCC_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")

endmodule

bind unix_time_calendar_convert utcc_checker u_utcc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

// ----- test/unix_time_calendar_convert_check.sv -----
// checker: predicts each calendar conversion and compares the posted results
`timescale 1ns / 1ps

module unix_time_calendar_convert_check
    import utcc_pkg::*;
#(
    parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  utcc_cmd_t   cmd,
    input  logic        busy,
    input  logic        done,
    input  utcc_rsp_t   rsp,
    output int unsigned mismatches,
    output int unsigned outstanding
);

    utcc_rsp_t   due_results[$];
    utcc_rsp_t   want;
    int unsigned results_seen;

    initial
    begin
        mismatches   = 0;
        outstanding  = 0;
        results_seen = 0;
    end

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned year_days(input int unsigned y);
        return leap_year(y) ? 366 : 365;
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        int unsigned len;
        case (m)
            2:             len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   len = 30;
            default:       len = 31;
        endcase
        return len;
    endfunction

    // days from the epoch to january 1 of year y
    function automatic longint unsigned days_before_year(input int unsigned y);
        longint unsigned days;
        int unsigned     k;
        days = 0;
        for (k = 1970; k < y; k++)
            days += year_days(k);
        return days;
    endfunction

    function automatic utcc_rsp_t predict_calendar(input utcc_cmd_t c);
        utcc_rsp_t       r;
        longint unsigned ceiling;
        longint unsigned days;
        longint unsigned total;
        int unsigned     y;
        int unsigned     m;
        int unsigned     d;
        int unsigned     k;
        int unsigned     tod;
        ceiling = days_before_year(MAX_YEAR + 1) * 64'd86400 - 64'd1;
        if (c.op == 1'b0)
        begin
            y = c.cal_year;
            m = c.cal_month;
            d = c.cal_day;
            if (y < 1970)
                y = 1970;
            if (y > MAX_YEAR)
                y = MAX_YEAR;
            if (m < 1)
                m = 1;
            if (m > 12)
                m = 12;
            if (d < 1)
                d = 1;
            days = days_before_year(y);
            for (k = 1; k < m; k++)
                days += month_length(k, y);
            days += d - 1;
            total = days * 64'd86400 + 64'(c.cal_hour) * 64'd3600
                  + 64'(c.cal_minute) * 64'd60 + 64'(c.cal_second);
            if (total > ceiling)
                total = ceiling;
            r.result_seconds = total[37:0];
            r.out_year       = c.cal_year;
            r.out_month      = c.cal_month;
            r.out_day        = c.cal_day;
            r.out_hour       = c.cal_hour;
            r.out_minute     = c.cal_minute;
            r.out_second     = c.cal_second;
        end
        else
        begin
            total = 64'(c.epoch_seconds);
            if (total > ceiling)
                total = ceiling;
            days = total / 64'd86400;
            tod  = int'(total % 64'd86400);
            y    = 1970;
            m    = 1;
            while (days >= year_days(y))
            begin
                days -= year_days(y);
                y++;
            end
            while (m < 12 && days >= month_length(m, y))
            begin
                days -= month_length(m, y);
                m++;
            end
            r.result_seconds = total[37:0];
            r.out_year       = 14'(y);
            r.out_month      = 4'(m);
            r.out_day        = 5'(days + 1);
            r.out_hour       = 5'(tod / 3600);
            r.out_minute     = 6'((tod % 3600) / 60);
            r.out_second     = 6'(tod % 60);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] exp_v);
        if (got !== exp_v)
            report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                      results_seen, name, got, exp_v));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (due_results.size() == 0)
                    report_mismatch($sformatf("result %0d with no transfer waiting",
                                              results_seen));
                else
                begin
                    want = due_results.pop_front();
                    compare_field("result_seconds", rsp.result_seconds, want.result_seconds);
                    compare_field("out_year", rsp.out_year, want.out_year);
                    compare_field("out_month", rsp.out_month, want.out_month);
                    compare_field("out_day", rsp.out_day, want.out_day);
                    compare_field("out_hour", rsp.out_hour, want.out_hour);
                    compare_field("out_minute", rsp.out_minute, want.out_minute);
                    compare_field("out_second", rsp.out_second, want.out_second);
                end
                results_seen++;
            end
            if (start && !busy)
                due_results.push_back(predict_calendar(cmd));
            outstanding <= due_results.size();
        end
    end

endmodule

// ----- test/unix_time_calendar_convert_test.sv -----
// testbench top: drives conversion commands and gives the verdict
`timescale 1ns / 1ps

module unix_time_calendar_convert_test;
    import utcc_pkg::*;

    localparam int unsigned QUIET_LIMIT = 40000;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    utcc_cmd_t   cmd   = '0;
    logic        busy;
    logic        done;
    utcc_rsp_t   rsp;
    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned quiet_cycles = 0;

    unix_time_calendar_convert dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    unix_time_calendar_convert_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .busy        (busy),
        .done        (done),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("unix_time_calendar_convert_test: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic utcc_cmd_t cal_cmd(input int unsigned y, input int unsigned mo,
                                          input int unsigned d, input int unsigned h,
                                          input int unsigned mi, input int unsigned s);
        utcc_cmd_t c;
        c.op            = 1'b0;
        c.epoch_seconds = 38'(((64'($urandom)) << 32) | 64'($urandom));
        c.cal_year      = 14'(y);
        c.cal_month     = 4'(mo);
        c.cal_day       = 5'(d);
        c.cal_hour      = 5'(h);
        c.cal_minute    = 6'(mi);
        c.cal_second    = 6'(s);
        return c;
    endfunction

    function automatic utcc_cmd_t secs_cmd(input logic [37:0] t);
        utcc_cmd_t c;
        c = cal_cmd($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        c.op            = 1'b1;
        c.epoch_seconds = t;
        return c;
    endfunction

    // start drops at random unless steady is set
    task automatic issue(input utcc_cmd_t c, input bit steady);
        bit on;
        bit taken;
        taken = 1'b0;
        on    = steady || ($urandom_range(99, 0) >= 19);
        cmd   <= c;
        start <= on;
        while (!taken)
        begin
            @(posedge clk);
            if (on && !busy)
                taken = 1'b1;
            else
            begin
                on    = steady || ($urandom_range(99, 0) >= 19);
                start <= on;
            end
        end
    endtask

    initial
    begin : stimulus
        utcc_cmd_t       c;
        longint unsigned t;
        int unsigned     n;
        int unsigned     pick;
        bit              steady;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // calendar to seconds
        issue(cal_cmd(1970, 1, 1, 0, 0, 0), 1'b0);
        issue(cal_cmd(9999, 12, 31, 23, 59, 59), 1'b0);
        issue(cal_cmd(2000, 2, 29, 12, 30, 45), 1'b0);
        issue(cal_cmd(2100, 2, 29, 0, 0, 0), 1'b0);
        issue(cal_cmd(2038, 1, 19, 3, 14, 7), 1'b0);
        issue(cal_cmd(0, 6, 15, 8, 0, 0), 1'b0);
        issue(cal_cmd(16383, 3, 3, 3, 3, 3), 1'b0);
        issue(cal_cmd(2024, 0, 10, 1, 2, 3), 1'b0);
        issue(cal_cmd(2024, 15, 10, 1, 2, 3), 1'b0);
        issue(cal_cmd(1999, 7, 0, 4, 5, 6), 1'b0);
        issue(cal_cmd(2023, 2, 31, 0, 0, 0), 1'b0);
        issue(cal_cmd(1980, 5, 5, 31, 63, 63), 1'b0);
        issue(cal_cmd(9999, 12, 31, 31, 63, 63), 1'b0);
        // seconds to calendar
        issue(secs_cmd(38'd0), 1'b0);
        issue(secs_cmd(38'd1), 1'b0);
        issue(secs_cmd(38'd86399), 1'b0);
        issue(secs_cmd(38'd86400), 1'b0);
        issue(secs_cmd(38'd94607999), 1'b0);
        issue(secs_cmd(38'd951782400), 1'b0);
        issue(secs_cmd(38'd951868800), 1'b0);
        issue(secs_cmd(38'd2147483647), 1'b0);
        issue(secs_cmd(38'd4107542399), 1'b0);
        issue(secs_cmd(38'd253402300799), 1'b0);
        issue(secs_cmd(38'd253402300800), 1'b0);
        issue(secs_cmd(38'h3F_FFFF_FFFF), 1'b0);

        for (n = 0; n < 75; n++)
        begin
            steady = (n >= 20 && n < 50);
            pick   = $urandom_range(99, 0);
            if ($urandom_range(1, 0) == 0)
            begin
                if (pick < 75)
                    c = cal_cmd((pick < 68) ? $urandom_range(2250, 1970)
                                            : $urandom_range(9999, 1970),
                                $urandom_range(12, 1), $urandom_range(31, 1),
                                $urandom_range(23, 0), $urandom_range(59, 0),
                                $urandom_range(59, 0));
                else
                    c = cal_cmd($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom);
            end
            else
            begin
                if (pick < 60)
                    t = (64'($urandom_range(1, 0)) << 32) | 64'($urandom);
                else if (pick < 80)
                    t = 64'($urandom_range(2932896, 0)) * 64'd86400
                      + ($urandom_range(1, 0) ? 64'd86399 : 64'd0);
                else
                    t = (64'($urandom_range(63, 0)) << 32) | 64'($urandom);
                c = secs_cmd(t[37:0]);
            end
            issue(c, steady);
        end
        start <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("unix_time_calendar_convert_test: done, clean");
        else
            $display("unix_time_calendar_convert_test: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/utcc_pkg.sv
design/utcc_datapath.sv
design/unix_time_calendar_convert.sv
design/utcc_checker.sv
test/unix_time_calendar_convert_check.sv
test/unix_time_calendar_convert_test.sv
